>>> rtl/vtn_pkg.sv
// Shared types and constants for the volume threshold notifier.
package vtn_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    localparam logic [31:0] KMAX_U32 = 32'hFFFF_FFFF;

    localparam logic [1:0] MODE_REQUEST = 2'd0;
    localparam logic [1:0] MODE_CANCEL  = 2'd1;
    localparam logic [1:0] MODE_VOLUME  = 2'd2;

    localparam logic [2:0] KIND_DONE      = 3'd0;
    localparam logic [2:0] KIND_REACHED   = 3'd1;
    localparam logic [2:0] KIND_ALREADY   = 3'd2;
    localparam logic [2:0] KIND_CANCELLED = 3'd3;
    localparam logic [2:0] KIND_IN_USE    = 3'd4;
    localparam logic [2:0] KIND_FULL      = 3'd5;

    localparam logic [1:0] OP_NONE   = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_DROP   = 2'd2;

    typedef struct packed {
        logic [31:0] thr;
        logic        wr;
        logic        mk;
        logic [31:0] cl;
    } slot_t;

    typedef struct packed {
        logic [1:0]       op;
        logic             dir;
        logic [IDX_W-1:0] pos;
        slot_t            data;
    } tbl_cmd_t;

endpackage

>>> rtl/volume_threshold_notifier_top.sv
// Volume threshold notifier: request/cancel/volume sequencer around the tables.
//
// Input channel (s_*): one word per request, cancel or volume-reached
// notification, accepted when s_valid and s_ready are both high. s_ready is
// high only while the sequencer is idle; one word is handled at a time.
// Result channel (m_*): one or more result words per input word, the final
// one flagged by m_last. Every result carries the head threshold register of
// its table as it stands after the decide step; a cancel does not update it.
// Sequence: after the accept each word scans the selected table one slot
// a cycle plus a closing check, then takes a decide step; a volume word
// then pops its entries one by one plus a closing pop step, and a word
// with a single result takes an output step. The scan of the single
// table read port sets the length of a word.
// Results sit in an output register: a stalled receiver holds the
// sequencer in its emit step, but a new input word may be accepted while
// the final result still waits.
// Reset (aresetn low, synchronous) leaves each table with only its wrap
// marker at all ones and both head thresholds at all ones.
module volume_threshold_notifier_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic        s_direction,
    input  logic [31:0] s_client_id,
    input  logic [31:0] s_delta,
    input  logic [31:0] s_absolute_threshold,
    input  logic [31:0] s_volume,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_kind,
    output logic [31:0] m_client_id_out,
    output logic [31:0] m_reported_volume,
    output logic        m_direction_out,
    output logic [31:0] m_next_threshold,
    output logic        m_last
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_DECIDE = 3'd2;
    localparam logic [2:0] ST_POP    = 3'd3;
    localparam logic [2:0] ST_OUT    = 3'd4;

    localparam int IW = vtn_pkg::IDX_W;
    localparam int CW = vtn_pkg::CNT_W;

    logic [2:0]  state_reg, state_next;
    logic [1:0]  mode_reg, mode_next;
    logic        dir_reg, dir_next;
    logic [31:0] cid_reg, cid_next;
    logic [31:0] vol_reg, vol_next;
    logic [31:0] thr_new_reg, thr_new_next;
    logic        wr_new_reg, wr_new_next;
    logic [32:0] eff_new_reg, eff_new_next;
    logic        abs_hit_reg, abs_hit_next;

    logic [CW-1:0] idx_reg, idx_next;
    logic          found_reg, found_next;
    logic [IW-1:0] fidx_reg, fidx_next;
    logic          posdone_reg, posdone_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic          popstop_reg, popstop_next;
    logic [CW-1:0] popcnt_reg, popcnt_next;
    logic [CW-1:0] nm_reg, nm_next;
    logic          any_reg, any_next;
    logic [31:0]   cand_reg, cand_next;

    logic [2:0]  res_kind_reg, res_kind_next;
    logic [31:0] res_cl_reg, res_cl_next;
    logic [31:0] res_vol_reg, res_vol_next;

    logic [31:0] head_reg [2];
    logic [31:0] head_next [2];

    logic        m_valid_reg, m_valid_next;
    logic [2:0]  m_kind_reg, m_kind_next;
    logic [31:0] m_cl_reg, m_cl_next;
    logic [31:0] m_vol_reg, m_vol_next;
    logic        m_dir_reg, m_dir_next;
    logic [31:0] m_nt_reg, m_nt_next;
    logic        m_last_reg, m_last_next;

    vtn_pkg::tbl_cmd_t cmd;
    vtn_pkg::slot_t    rd_slot;
    logic [CW-1:0]     rd_count;
    logic [IW-1:0]     rd_idx;
    logic [32:0]       sum33;
    logic [32:0]       eff_x;
    logic              out_free;

    assign rd_idx = (state_reg == ST_SCAN) ? idx_reg[IW-1:0] : '0;

    vtn_table u_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .rd_dir   (dir_reg),
        .rd_idx   (rd_idx),
        .rd_slot  (rd_slot),
        .rd_count (rd_count)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;
    assign sum33    = {1'b0, s_volume} + {1'b0, s_delta};
    assign eff_x    = {1'b0, rd_slot.thr} + (rd_slot.wr ? {1'b0, vtn_pkg::KMAX_U32} : 33'd0);

    assign m_valid           = m_valid_reg;
    assign m_kind            = m_kind_reg;
    assign m_client_id_out   = m_cl_reg;
    assign m_reported_volume = m_vol_reg;
    assign m_direction_out   = m_dir_reg;
    assign m_next_threshold  = m_nt_reg;
    assign m_last            = m_last_reg;

    always_comb begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        dir_next      = dir_reg;
        cid_next      = cid_reg;
        vol_next      = vol_reg;
        thr_new_next  = thr_new_reg;
        wr_new_next   = wr_new_reg;
        eff_new_next  = eff_new_reg;
        abs_hit_next  = abs_hit_reg;
        idx_next      = idx_reg;
        found_next    = found_reg;
        fidx_next     = fidx_reg;
        posdone_next  = posdone_reg;
        pos_next      = pos_reg;
        popstop_next  = popstop_reg;
        popcnt_next   = popcnt_reg;
        nm_next       = nm_reg;
        any_next      = any_reg;
        cand_next     = cand_reg;
        res_kind_next = res_kind_reg;
        res_cl_next   = res_cl_reg;
        res_vol_next  = res_vol_reg;
        head_next     = head_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_kind_next   = m_kind_reg;
        m_cl_next     = m_cl_reg;
        m_vol_next    = m_vol_reg;
        m_dir_next    = m_dir_reg;
        m_nt_next     = m_nt_reg;
        m_last_next   = m_last_reg;
        cmd           = '0;
        cmd.dir       = dir_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    mode_next    = s_mode;
                    dir_next     = s_direction;
                    cid_next     = s_client_id;
                    vol_next     = s_volume;
                    abs_hit_next = (s_delta == 32'd0) && (s_volume >= s_absolute_threshold);
                    if (s_delta == 32'd0) begin
                        thr_new_next = s_absolute_threshold;
                        wr_new_next  = 1'b0;
                        eff_new_next = {1'b0, s_absolute_threshold};
                    end else begin
                        // wrapped: s - 0xFFFFFFFF is the low word plus one
                        thr_new_next = sum33[32] ? sum33[31:0] + 32'd1 : sum33[31:0];
                        wr_new_next  = sum33[32];
                        eff_new_next = sum33;
                    end
                    idx_next     = '0;
                    found_next   = 1'b0;
                    fidx_next    = '0;
                    posdone_next = 1'b0;
                    pos_next     = '0;
                    popstop_next = 1'b0;
                    popcnt_next  = '0;
                    nm_next      = '0;
                    cand_next    = '0;
                    state_next   = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (idx_reg == rd_count) begin
                    if (!posdone_reg) pos_next = rd_count;
                    state_next = ST_DECIDE;
                end else begin
                    if (!found_reg && !rd_slot.mk && rd_slot.cl == cid_reg) begin
                        found_next = 1'b1;
                        fidx_next  = idx_reg[IW-1:0];
                    end
                    if (!posdone_reg && eff_x > eff_new_reg) begin
                        posdone_next = 1'b1;
                        pos_next     = idx_reg;
                    end
                    if (!popstop_reg) begin
                        if (vol_reg >= rd_slot.thr) begin
                            popcnt_next = popcnt_reg + 1'b1;
                            if (!rd_slot.mk) nm_next = nm_reg + 1'b1;
                        end else begin
                            popstop_next = 1'b1;
                            cand_next    = rd_slot.thr;
                        end
                    end
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_DECIDE: begin
                res_cl_next  = cid_reg;
                res_vol_next = '0;
                res_kind_next = vtn_pkg::KIND_DONE;
                state_next   = ST_OUT;
                case (mode_reg)
                    vtn_pkg::MODE_REQUEST: begin
                        if (found_reg) begin
                            res_kind_next = vtn_pkg::KIND_IN_USE;
                        end else if (abs_hit_reg) begin
                            res_kind_next = vtn_pkg::KIND_ALREADY;
                            res_vol_next  = vol_reg;
                        end else if (rd_count >= CW'(vtn_pkg::TABLE_DEPTH)) begin
                            res_kind_next = vtn_pkg::KIND_FULL;
                        end else begin
                            cmd.op       = vtn_pkg::OP_INSERT;
                            cmd.pos      = pos_reg[IW-1:0];
                            cmd.data.thr = thr_new_reg;
                            cmd.data.wr  = wr_new_reg;
                            cmd.data.mk  = 1'b0;
                            cmd.data.cl  = cid_reg;
                            head_next[dir_reg] = (pos_reg == '0) ? thr_new_reg : rd_slot.thr;
                        end
                    end
                    vtn_pkg::MODE_CANCEL: begin
                        if (found_reg) begin
                            cmd.op        = vtn_pkg::OP_DROP;
                            cmd.pos       = fidx_reg;
                            res_kind_next = vtn_pkg::KIND_CANCELLED;
                        end
                    end
                    vtn_pkg::MODE_VOLUME: begin
                        // all-ones volume pops everything, leaving only a fresh marker
                        if (vol_reg == vtn_pkg::KMAX_U32) begin
                            head_next[dir_reg] = vtn_pkg::KMAX_U32;
                        end else if (popstop_reg) begin
                            head_next[dir_reg] = cand_reg;
                        end
                        any_next   = (nm_reg != '0);
                        res_cl_next = '0;
                        state_next = ST_POP;
                    end
                    default: begin
                    end
                endcase
            end
            ST_POP: begin
                if (popcnt_reg == '0) begin
                    if (vol_reg == vtn_pkg::KMAX_U32) begin
                        cmd.op       = vtn_pkg::OP_INSERT;
                        cmd.pos      = '0;
                        cmd.data.thr = vtn_pkg::KMAX_U32;
                        cmd.data.wr  = 1'b0;
                        cmd.data.mk  = 1'b1;
                        cmd.data.cl  = '0;
                    end
                    state_next = any_reg ? ST_IDLE : ST_OUT;
                end else if (rd_slot.mk) begin
                    cmd.op      = vtn_pkg::OP_DROP;
                    cmd.pos     = '0;
                    popcnt_next = popcnt_reg - 1'b1;
                end else if (out_free) begin
                    cmd.op       = vtn_pkg::OP_DROP;
                    cmd.pos      = '0;
                    popcnt_next  = popcnt_reg - 1'b1;
                    nm_next      = nm_reg - 1'b1;
                    m_valid_next = 1'b1;
                    m_kind_next  = vtn_pkg::KIND_REACHED;
                    m_cl_next    = rd_slot.cl;
                    m_vol_next   = vol_reg;
                    m_dir_next   = dir_reg;
                    m_nt_next    = head_reg[dir_reg];
                    m_last_next  = (nm_reg == CW'(1));
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = res_kind_reg;
                    m_cl_next    = res_cl_reg;
                    m_vol_next   = res_vol_reg;
                    m_dir_next   = dir_reg;
                    m_nt_next    = head_reg[dir_reg];
                    m_last_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            head_reg[0] <= vtn_pkg::KMAX_U32;
            head_reg[1] <= vtn_pkg::KMAX_U32;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            head_reg    <= head_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg     <= mode_next;
        dir_reg      <= dir_next;
        cid_reg      <= cid_next;
        vol_reg      <= vol_next;
        thr_new_reg  <= thr_new_next;
        wr_new_reg   <= wr_new_next;
        eff_new_reg  <= eff_new_next;
        abs_hit_reg  <= abs_hit_next;
        idx_reg      <= idx_next;
        found_reg    <= found_next;
        fidx_reg     <= fidx_next;
        posdone_reg  <= posdone_next;
        pos_reg      <= pos_next;
        popstop_reg  <= popstop_next;
        popcnt_reg   <= popcnt_next;
        nm_reg       <= nm_next;
        any_reg      <= any_next;
        cand_reg     <= cand_next;
        res_kind_reg <= res_kind_next;
        res_cl_reg   <= res_cl_next;
        res_vol_reg  <= res_vol_next;
        m_kind_reg   <= m_kind_next;
        m_cl_reg     <= m_cl_next;
        m_vol_reg    <= m_vol_next;
        m_dir_reg    <= m_dir_next;
        m_nt_reg     <= m_nt_next;
        m_last_reg   <= m_last_next;
    end

endmodule

>>> rtl/vtn_table.sv
// Two sorted threshold tables with insert/drop shifting and one read port.
module vtn_table (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  vtn_pkg::tbl_cmd_t              cmd,
    input  logic                           rd_dir,
    input  logic [vtn_pkg::IDX_W-1:0]      rd_idx,
    output vtn_pkg::slot_t                 rd_slot,
    output logic [vtn_pkg::CNT_W-1:0]      rd_count
);

    vtn_pkg::slot_t             slot_reg  [2][vtn_pkg::TABLE_DEPTH];
    vtn_pkg::slot_t             slot_next [2][vtn_pkg::TABLE_DEPTH];
    logic [vtn_pkg::CNT_W-1:0]  count_reg  [2];
    logic [vtn_pkg::CNT_W-1:0]  count_next [2];

    assign rd_slot  = slot_reg[rd_dir][rd_idx];
    assign rd_count = count_reg[rd_dir];

    always_comb begin
        slot_next  = slot_reg;
        count_next = count_reg;
        case (cmd.op)
            vtn_pkg::OP_INSERT: begin
                for (int i = 0; i < vtn_pkg::TABLE_DEPTH; i++) begin
                    if (vtn_pkg::IDX_W'(i) == cmd.pos) begin
                        slot_next[cmd.dir][i] = cmd.data;
                    end else if (vtn_pkg::IDX_W'(i) > cmd.pos) begin
                        slot_next[cmd.dir][i] = slot_reg[cmd.dir][(i == 0) ? 0 : i - 1];
                    end
                end
                count_next[cmd.dir] = count_reg[cmd.dir] + 1'b1;
            end
            vtn_pkg::OP_DROP: begin
                for (int i = 0; i < vtn_pkg::TABLE_DEPTH - 1; i++) begin
                    if (vtn_pkg::IDX_W'(i) >= cmd.pos) begin
                        slot_next[cmd.dir][i] = slot_reg[cmd.dir][i + 1];
                    end
                end
                count_next[cmd.dir] = count_reg[cmd.dir] - 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int d = 0; d < 2; d++) begin
                for (int i = 0; i < vtn_pkg::TABLE_DEPTH; i++) begin
                    slot_reg[d][i] <= '0;
                end
                slot_reg[d][0].thr <= vtn_pkg::KMAX_U32;
                slot_reg[d][0].mk  <= 1'b1;
                count_reg[d]       <= vtn_pkg::CNT_W'(1);
            end
        end else begin
            slot_reg  <= slot_next;
            count_reg <= count_next;
        end
    end

endmodule
